>>> hw/rtl/mfb_pkg.sv
// Shared types and constants of the monochrome framebuffer fill engine.
// Holds request field positions, command codes and the control/status structs.
// No dependencies.
package mfb_pkg;

   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = 12;
   localparam int COORD_W     = 18;

   localparam int REQ_DATA_W  = 80;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 8;
   localparam int RSP_USER_W  = 1;

   // Request tdata field positions
   localparam int POS_X_LSB   = 0;
   localparam int POS_Y_LSB   = 16;
   localparam int RECT_W_LSB  = 32;
   localparam int RECT_H_LSB  = 48;
   localparam int INK_BIT     = 64;
   localparam int BADDR_LSB   = 65;

   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [2:0] BIT_MAX   = 3'd7;

   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_FILL  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic clip;
      logic setup;
      logic mem_read;
      logic mem_write;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [1:0] kind;
      logic       empty;
      logic       last_byte;
      logic       rsp_free;
   } dp_stat_type;

endpackage

>>> hw/rtl/mfb_ctrl.sv
// Sequencer of the framebuffer fill engine: clearing pass, clip, row/byte walk.
// Depends on mfb_pkg; drives mfb_datapath through ctrl_cmd_type.
module mfb_ctrl
   import mfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CLIP  = 3'd2;
   localparam logic [2:0] S_SETUP = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CLIP;
            end
         end
         S_CLIP: begin
            cmd.clip = 1'b1;
            unique case (stat.kind)
               CMD_READ: begin
                  cmd.mem_read = 1'b1;
                  state_in     = S_DONE;
               end
               CMD_NONE: begin
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_SETUP;
               end
            endcase
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = stat.empty ? S_DONE : S_READ;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_WRITE;
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = stat.last_byte ? S_DONE : S_READ;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> $past(state_ff) == S_READ)
      else $error("write step without a preceding read step");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_CLEAR && state_ff != S_CLEAR) |-> $past(stat.clear_last))
      else $error("clearing pass left early");

   a_idle_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) != S_IDLE)
         |-> ($past(state_ff) == S_DONE || $past(state_ff) == S_CLEAR))
      else $error("idle entered before the result was handed off");
`endif

endmodule

>>> hw/rtl/mfb_datapath.sv
// Datapath of the framebuffer fill engine: request registers, clipping,
// byte walk counters, the 4096 x 8 frame store and the result register.
// Depends on mfb_pkg; steered by mfb_ctrl.
module mfb_datapath
   import mfb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 128,
   parameter int ROW_BYTES     = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  ctrl_cmd_type          cmd,
   output dp_stat_type           stat
);

   localparam int XW      = $clog2(SCREEN_WIDTH) + 1;
   localparam int BW      = XW - 3;
   localparam int YW      = $clog2(SCREEN_HEIGHT) + 1;
   localparam int IDX_RAW = $clog2(SCREEN_HEIGHT * ROW_BYTES + SCREEN_WIDTH / 8 + 1);
   localparam int IDX_W   = (IDX_RAW > ADDR_W) ? IDX_RAW : ADDR_W;

   localparam logic signed [COORD_W-1:0] SCR_W = COORD_W'(SCREEN_WIDTH);
   localparam logic signed [COORD_W-1:0] SCR_H = COORD_W'(SCREEN_HEIGHT);

   // Request registers
   logic [1:0]         kind_ff;
   logic signed [15:0] x_ff, y_ff, w_ff, h_ff;
   logic               ink_ff;
   logic [ADDR_W-1:0]  baddr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= CMD_NONE;
      end else if (cmd.load_req) begin
         kind_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         x_ff     <= req_tdata[POS_X_LSB +: 16];
         y_ff     <= req_tdata[POS_Y_LSB +: 16];
         // a pixel is a one by one rectangle
         w_ff     <= (req_tuser == CMD_PIXEL) ? 16'sd1 : req_tdata[RECT_W_LSB +: 16];
         h_ff     <= (req_tuser == CMD_PIXEL) ? 16'sd1 : req_tdata[RECT_H_LSB +: 16];
         ink_ff   <= req_tdata[INK_BIT];
         baddr_ff <= req_tdata[BADDR_LSB +: ADDR_W];
      end
   end

   // Clip the near edges, keep far edges as exclusive ends
   logic signed [COORD_W-1:0] x_s, y_s, w_s, h_s;
   logic signed [COORD_W-1:0] xc_in, yc_in, wc_in, hc_in, xe_in, ye_in;
   logic                      empty_in;
   logic signed [COORD_W-1:0] xc_ff, yc_ff, xe_ff, ye_ff;
   logic                      empty_ff;

   always_comb begin
      x_s      = $signed({{(COORD_W-16){x_ff[15]}}, x_ff});
      y_s      = $signed({{(COORD_W-16){y_ff[15]}}, y_ff});
      w_s      = $signed({{(COORD_W-16){w_ff[15]}}, w_ff});
      h_s      = $signed({{(COORD_W-16){h_ff[15]}}, h_ff});
      xc_in    = x_ff[15] ? '0 : x_s;
      wc_in    = x_ff[15] ? (w_s + x_s) : w_s;
      yc_in    = y_ff[15] ? '0 : y_s;
      hc_in    = y_ff[15] ? (h_s + y_s) : h_s;
      xe_in    = xc_in + wc_in;
      ye_in    = yc_in + hc_in;
      empty_in = (xc_in >= SCR_W) || (yc_in >= SCR_H) ||
                 (wc_in <= 0) || (hc_in <= 0);
   end

   always_ff @(posedge clock) begin
      if (cmd.clip) begin
         xc_ff    <= xc_in;
         yc_ff    <= yc_in;
         xe_ff    <= xe_in;
         ye_ff    <= ye_in;
         empty_ff <= empty_in;
      end
   end

   // Byte bounds, edge masks and first row base
   logic signed [COORD_W-1:0] x2_s, y2_s;
   logic [XW-1:0]             x_lo, x_hi;
   logic [YW-1:0]             y_lo;
   logic [BW-1:0]             bl_ff, br_ff, col_ff;
   logic [7:0]                ml_ff, mr_ff;
   logic [YW-1:0]             row_ff, y2_ff;
   logic [IDX_W-1:0]          base_ff;

   always_comb begin
      x2_s = ((xe_ff > SCR_W) ? SCR_W : xe_ff) - COORD_W'(1);
      y2_s = ((ye_ff > SCR_H) ? SCR_H : ye_ff) - COORD_W'(1);
      x_lo = xc_ff[XW-1:0];
      x_hi = x2_s[XW-1:0];
      y_lo = yc_ff[YW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         bl_ff   <= x_lo[XW-1:3];
         br_ff   <= x_hi[XW-1:3];
         ml_ff   <= BYTE_ONES >> x_lo[2:0];
         mr_ff   <= BYTE_ONES << (BIT_MAX - x_hi[2:0]);
         col_ff  <= x_lo[XW-1:3];
         row_ff  <= y_lo;
         y2_ff   <= y2_s[YW-1:0];
         base_ff <= IDX_W'(y_lo) * IDX_W'(ROW_BYTES);
      end else if (cmd.mem_write) begin
         if (col_ff == br_ff) begin
            col_ff  <= bl_ff;
            row_ff  <= row_ff + 1'b1;
            base_ff <= base_ff + IDX_W'(ROW_BYTES);
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   logic [IDX_W-1:0] fill_addr;
   logic             in_store;
   logic [7:0]       mask;

   always_comb begin
      fill_addr = base_ff + IDX_W'(col_ff);
      in_store  = 32'(fill_addr) < STORE_DEPTH;
      mask      = BYTE_ONES;
      if (col_ff == bl_ff) begin
         mask = mask & ml_ff;
      end
      if (col_ff == br_ff) begin
         mask = mask & mr_ff;
      end
   end

   // Frame store with clearing pass
   logic [ADDR_W-1:0] clr_ff;
   logic [7:0]        mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [7:0]        wr_data;
   logic              wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_comb begin
      rd_addr = (kind_ff == CMD_READ) ? baddr_ff : fill_addr[ADDR_W-1:0];
      wr_en   = cmd.clear_step || (cmd.mem_write && in_store);
      wr_addr = cmd.clear_step ? clr_ff : fill_addr[ADDR_W-1:0];
      if (cmd.clear_step) begin
         wr_data = BYTE_ONES;
      end else if (ink_ff) begin
         wr_data = rd_data_ff & ~mask;
      end else begin
         wr_data = rd_data_ff | mask;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= (kind_ff == CMD_READ) ? rd_data_ff : '0;
         rsp_user_ff <= RSP_USER_W'(((kind_ff == CMD_PIXEL) || (kind_ff == CMD_FILL))
                                    && empty_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      stat.clear_last = (clr_ff == ADDR_W'(STORE_DEPTH - 1));
      stat.kind       = kind_ff;
      stat.empty      = empty_ff;
      stat.last_byte  = (col_ff == br_ff) && (row_ff == y2_ff);
      stat.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

`ifndef SYNTHESIS
   a_rmw_same_addr: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> ($past(cmd.mem_read) && $past(fill_addr) == fill_addr))
      else $error("store write does not follow a read of the same byte");

   a_col_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> (col_ff >= bl_ff && col_ff <= br_ff))
      else $error("byte column outside the clipped span");

   a_row_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> row_ff <= y2_ff)
      else $error("row walk passed the clipped bottom row");
`endif

endmodule

>>> hw/rtl/mono_framebuffer_rect_fill.sv
// Top level of the monochrome 1 bpp framebuffer drawing engine.
// Depends on mfb_pkg, mfb_ctrl and mfb_datapath.
//
// Usage:
//   Requests enter on req_* (accepted when req_tvalid and req_tready are high),
//   one result per request leaves on rsp_* (taken when rsp_tvalid and
//   rsp_tready are high). req_tuser carries the command: set pixel, fill
//   rectangle, read byte. Rectangles and pixels are clipped to the screen.
// Sequence (request accept to result valid):
//   read byte or unknown command: clip, then done.
//   set pixel and fill: clip, setup, then a read step and a write step per
//   byte, since each byte takes a read and a write on the single frame store.
//   A clipped-away pixel or rectangle: clip, setup, then done.
//   The next request is taken in the cycle after the result loads.
// Reset: a clearing pass writes 0xFF into all 4096 store bytes,
//   with req_tready low for the whole pass.
// Stall: a finished result waits in the output register; the next request is
//   accepted meanwhile, and its own result holds until the register frees up.
module mono_framebuffer_rect_fill
   import mfb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 128,
   parameter int ROW_BYTES     = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x[15:0], pos_y[31:16], rect_w[47:32], rect_h[63:48], ink_black[64],
   // byte_addr[76:65], zero fill [79:77]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_byte[7:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // nothing_drawn[0]
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // Sequencer: clearing pass, then one request at a time
   mfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_ready  (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Clipping, byte walk, frame store and result register
   mfb_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .ROW_BYTES     (ROW_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
